>>> rtl/lft_pkg.sv
// Shared types and constants for the LFU frequency table.
package lft_pkg;

	localparam int KEY_W          = 32;
	localparam int USE_COUNT_W    = 16;
	localparam int LFT_ENTRIES    = 64;
	localparam int LFT_COUNT_BITS = 16;

	typedef enum logic {
		KIND_ACCESS = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic [USE_COUNT_W-1:0] use_count;
		logic                   dropped;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic clear_wr;
		logic rd_issue;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic addr_last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/lft_stream_if.sv
// Valid/ready channel carrying one payload item.
interface lft_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

>>> rtl/lft_ctrl.sv
// Sequencer for the clearing pass, table scan and commit of each request.
module lft_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lft_pkg::sts_t sts,
	output lft_pkg::cmd_t cmd
);
	import lft_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.addr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.addr_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign req_ready    = (state_q == ST_IDLE);
	assign cmd.load_in  = (state_q == ST_IDLE) && req_valid;
	assign cmd.clear_wr = (state_q == ST_CLEAR);
	assign cmd.rd_issue = (state_q == ST_SCAN);
	assign cmd.commit   = (state_q == ST_COMMIT) && sts.out_free;

`ifndef SYNTHESIS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.clear_wr, cmd.rd_issue, cmd.commit}))
		else $error("more than one datapath command at once");

	a_scan_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.addr_last |=> (state_q == ST_DRAIN))
		else $error("scan did not end after the last entry");
`endif
endmodule

>>> rtl/lft_dp.sv
// Datapath: request register, entry store, scan trackers and result register.
module lft_dp #(
	parameter int ENTRIES    = lft_pkg::LFT_ENTRIES,
	parameter int COUNT_BITS = lft_pkg::LFT_COUNT_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lft_pkg::cmd_t cmd,
	output lft_pkg::sts_t sts,
	input  lft_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lft_pkg::rsp_t rsp_data
);
	import lft_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	typedef struct packed {
		logic                  valid;
		logic [KEY_W-1:0]      key;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	req_t                  req_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  addr_last;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	entry_t                rd_entry;
	logic                  match_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic [COUNT_BITS-1:0] match_cnt_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_entry;
	logic                  commit_wr;
	logic [IDX_W-1:0]      commit_addr;
	entry_t                commit_entry;
	logic [COUNT_BITS-1:0] cnt_inc;
	rsp_t                  rsp_d;

	lft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (cmd.rd_issue),
		.rd_addr(addr_q),
		.rd_data(rd_entry)
	);

	assign addr_last     = (addr_q == IDX_W'(ENTRIES - 1));
	assign sts.addr_last = addr_last;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	// Sweep address for both the clearing pass and the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				addr_q <= '0;
			end else if (cmd.clear_wr || cmd.rd_issue) begin
				addr_q <= addr_last ? '0 : addr_q + IDX_W'(1);
			end
			rd_vld_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (cmd.load_in) begin
			req_q <= req_data;
		end
	end

	// Track the matching entry and the lowest free entry as data returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load_in) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_entry.valid && (rd_entry.key == req_q.key) && !match_q) begin
				match_q <= 1'b1;
			end
			if (!rd_entry.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_entry.valid && (rd_entry.key == req_q.key) && !match_q) begin
			match_idx_q <= rd_idx_s1;
			match_cnt_q <= rd_entry.count;
		end
		if (rd_vld_s1 && !rd_entry.valid && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// Saturating count-up
	assign cnt_inc = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + COUNT_BITS'(1);

	always_comb begin
		rsp_d        = '0;
		commit_wr    = 1'b0;
		commit_addr  = match_idx_q;
		commit_entry = '0;
		case (req_q.kind)
			KIND_ACCESS: begin
				if (match_q) begin
					rsp_d.hit          = 1'b1;
					rsp_d.use_count    = USE_COUNT_W'(cnt_inc);
					commit_wr          = 1'b1;
					commit_entry.valid = 1'b1;
					commit_entry.key   = req_q.key;
					commit_entry.count = cnt_inc;
				end else if (free_q) begin
					rsp_d.use_count    = USE_COUNT_W'(1);
					commit_wr          = 1'b1;
					commit_addr        = free_idx_q;
					commit_entry.valid = 1'b1;
					commit_entry.key   = req_q.key;
					commit_entry.count = COUNT_BITS'(1);
				end else begin
					rsp_d.dropped = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (match_q) begin
					rsp_d.hit = 1'b1;
					commit_wr = 1'b1;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = addr_q;
		wr_entry = '0;
		if (cmd.clear_wr) begin
			wr_en = 1'b1;
		end else if (cmd.commit && commit_wr) begin
			wr_en    = 1'b1;
			wr_addr  = commit_addr;
			wr_entry = commit_entry;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten before it was taken");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.dropped |-> !rsp_q.hit && (rsp_q.use_count == '0))
		else $error("dropped request reports a hit or a count");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("commit did not present a result");
`endif
endmodule

>>> rtl/lfu_frequency_table_core.sv
// Top level of the LFU use-count table: controller, datapath and channels.
//
//  channel | dir | payload                      | handshake
//  req     | in  | kind, key                    | valid/ready
//  rsp     | out | hit, use_count, dropped      | valid/ready
//
// A request is taken only in the idle state, so the next request waits until the
// result of the previous one is committed: the entry store has one read port and
// the scan reads one entry per cycle, over every entry, before the commit.
// After reset a clearing pass writes every entry invalid before the first request.
// A new request is taken while a result still waits in the output register;
// the commit then holds until that result is taken.
module lfu_frequency_table_core #(
	parameter int ENTRIES    = lft_pkg::LFT_ENTRIES,
	parameter int COUNT_BITS = lft_pkg::LFT_COUNT_BITS
) (
	input logic         clk,
	input logic         arst_n,
	lft_stream_if.sink   req,
	lft_stream_if.source rsp
);
	import lft_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rsp_t rsp_data;
	logic rsp_valid;

	lft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lft_dp #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_data (req.data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp.ready),
		.rsp_data (rsp_data)
	);

	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;
endmodule

>>> test/tb_lfu_frequency_table_core.sv
// Self-checking testbench for the LFU use-count table core.
`timescale 1ns / 1ps

module tb_lfu_frequency_table_core;

	import lft_pkg::*;

	localparam int TBL_ENTRIES  = LFT_ENTRIES;
	localparam int CNT_BITS     = LFT_COUNT_BITS;
	localparam int ITEM_TOTAL   = 1450;
	localparam int POOL_SIZE    = 96;
	localparam int HOT_KEYS     = 12;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 500;
	localparam int IDLE_LIMIT   = 4000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lft_stream_if #(.payload_t(req_t)) req_ch ();
	lft_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	lfu_frequency_table_core #(
		.ENTRIES   (TBL_ENTRIES),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	class use_count_board;
		bit                  live  [TBL_ENTRIES];
		logic [KEY_W-1:0]    tag   [TBL_ENTRIES];
		logic [CNT_BITS-1:0] count [TBL_ENTRIES];
		rsp_t                awaited_counts[$];
		int                  reqs_seen;
		int                  errors;

		// Work out the result of one request and advance the table copy
		function void note_request(req_t r);
			int   slot;
			int   free_slot;
			rsp_t want;
			slot      = -1;
			free_slot = -1;
			want      = '0;
			for (int i = TBL_ENTRIES - 1; i >= 0; i--) begin
				if (live[i] && tag[i] == r.key)
					slot = i;
				if (!live[i])
					free_slot = i;
			end
			if (r.kind == KIND_ACCESS) begin
				if (slot >= 0) begin
					want.hit = 1'b1;
					if (count[slot] != '1)
						count[slot] = count[slot] + 1'b1;
					want.use_count = USE_COUNT_W'(count[slot]);
				end else if (free_slot >= 0) begin
					live[free_slot]  = 1'b1;
					tag[free_slot]   = r.key;
					count[free_slot] = CNT_BITS'(1);
					want.use_count   = USE_COUNT_W'(1);
				end else begin
					want.dropped = 1'b1;
				end
			end else if (slot >= 0) begin
				want.hit   = 1'b1;
				live[slot] = 1'b0;
			end
			awaited_counts.push_back(want);
			reqs_seen++;
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_counts.size() == 0) begin
				$error("result with no request outstanding: hit=%0b use_count=%0d dropped=%0b",
					got.hit, got.use_count, got.dropped);
				errors++;
				return;
			end
			want = awaited_counts.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0b, got %0b", want.hit, got.hit);
				errors++;
			end
			if (got.use_count !== want.use_count) begin
				$error("use_count: expected %0d, got %0d", want.use_count, got.use_count);
				errors++;
			end
			if (got.dropped !== want.dropped) begin
				$error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
				errors++;
			end
		endfunction
	endclass

	use_count_board board = new();

	int burst_left;
	int idle_cycles;

	// Observe both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_request(req_ch.data);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_result(rsp_ch.data);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Offer one request, with a random gap between bursts
	task automatic push_request(input kind_t kind, input logic [KEY_W-1:0] key);
		req_t r;
		int   gap;
		r.kind = kind;
		r.key  = key;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Receiver: stall on shifting patterns, with one long hold-off
	initial begin : rsp_stall
		int mode;
		int span;
		bit held;
		held         = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(40, 300);
			repeat (span) begin
				if (!held && board.reqs_seen >= HOLD_AT) begin
					held = 1'b1;
					rsp_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= $urandom_range(0, 1);
					2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 15) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] key_pool [POOL_SIZE];
		logic [KEY_W-1:0] key;
		kind_t            kind;
		int               sent;
		int               style;
		int               seg_len;
		int               span;
		int               rm_pct;
		int               noise_pct;

		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		burst_left   = 0;
		idle_cycles  = 0;
		sent         = 0;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes of the key, each placed in the lowest free entry
		push_request(KIND_ACCESS, 32'h8000_0000);
		push_request(KIND_ACCESS, 32'h7FFF_FFFF);
		push_request(KIND_ACCESS, 32'h0000_0000);
		push_request(KIND_ACCESS, 32'hFFFF_FFFF);
		// Count one key up repeatedly
		repeat (15) push_request(KIND_ACCESS, 32'h0000_0000);
		push_request(KIND_REMOVE, 32'h7FFF_FFFF);
		// Remove of an absent key
		push_request(KIND_REMOVE, 32'h7FFF_FFFF);
		// Refill the freed entry ahead of the higher free ones
		push_request(KIND_ACCESS, 32'h1234_5678);
		push_request(KIND_REMOVE, 32'h8000_0000);
		push_request(KIND_ACCESS, 32'hFFFF_FFFF);
		push_request(KIND_REMOVE, 32'h5555_AAAA);
		sent = 25;

		// Random segments: fill to full, hot keys, churn, noise
		while (sent < ITEM_TOTAL) begin
			style   = $urandom_range(0, 3);
			seg_len = $urandom_range(40, 160);
			case (style)
				0: begin span = POOL_SIZE; rm_pct = 3;  noise_pct = 3;  end
				1: begin span = HOT_KEYS;  rm_pct = 10; noise_pct = 3;  end
				2: begin span = POOL_SIZE; rm_pct = 40; noise_pct = 6;  end
				default: begin span = POOL_SIZE; rm_pct = 25; noise_pct = 50; end
			endcase
			for (int n = 0; n < seg_len && sent < ITEM_TOTAL; n++) begin
				kind = ($urandom_range(0, 99) < rm_pct) ? KIND_REMOVE : KIND_ACCESS;
				if ($urandom_range(0, 99) < noise_pct)
					key = $urandom;
				else
					key = key_pool[$urandom_range(0, span - 1)];
				push_request(kind, key);
				sent++;
			end
		end
		req_ch.valid <= 1'b0;

		while (board.awaited_counts.size() != 0)
			@(posedge clk);
		// Let any stray result surface before judging
		repeat (TBL_ENTRIES + 8) @(posedge clk);

		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
